>>> rtl/mvm_pkg.sv
`default_nettype none

package mvm_pkg;

    localparam int DIM       = 4;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int COL_W     = 2;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W + $clog2(DIM);
    localparam int SHIFT_W   = ACC_W - FRAC_BITS;
    localparam int USER_W    = 1 + COL_W;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_MUL  = 1'b1
    } cmd_t;

    localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // one beat travelling down the cell chain
    typedef struct packed {
        cmd_t                   cmd;
        logic [COL_W-1:0]       column;
        logic                   live;
        data_t [DIM-1:0]        vec;
        acc_t  [DIM-1:0]        acc;
    } mvm_item_t;

endpackage

`default_nettype wire

>>> rtl/mvm_cell.sv
`default_nettype none

module mvm_cell
    import mvm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire mvm_item_t in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output mvm_item_t      out_item
);

    data_t [DIM-1:0] col_reg;
    data_t [DIM-1:0] col_next;
    prod_t [DIM-1:0] prod_reg;
    prod_t [DIM-1:0] prod_next;
    mvm_item_t       a_item_reg;
    mvm_item_t       a_item_next;
    mvm_item_t       b_item_reg;
    mvm_item_t       b_item_next;
    logic            a_valid_reg;
    logic            a_valid_next;
    logic            b_valid_reg;
    logic            b_valid_next;
    logic            a_ready;
    logic            in_take;
    logic            a_take;
    logic            hit;

    assign a_ready  = !b_valid_reg || out_ready;
    assign in_ready = !a_valid_reg || a_ready;
    assign in_take  = in_valid && in_ready;
    assign a_take   = a_valid_reg && a_ready;

    assign hit = (in_item.cmd == CMD_LOAD) && in_item.live && (in_item.column == '0);

    // stage a: column write for loads, products for multiplies
    always_comb
    begin
        col_next    = col_reg;
        a_item_next = in_item;
        for (int r = 0; r < DIM; r++)
        begin
            prod_next[r] = $signed(col_reg[r]) * $signed(in_item.vec[0]);
        end
        if (in_take && hit)
        begin
            col_next = in_item.vec;
        end
        if (in_item.cmd == CMD_LOAD)
        begin
            a_item_next.column = in_item.column - COL_W'(1);
            a_item_next.live   = in_item.live && (in_item.column != '0);
        end
        else
        begin
            for (int r = 0; r < DIM - 1; r++)
            begin
                a_item_next.vec[r] = in_item.vec[r+1];
            end
            a_item_next.vec[DIM-1] = '0;
        end
    end

    // stage b: add products into the running sums
    always_comb
    begin
        b_item_next = a_item_reg;
        for (int r = 0; r < DIM; r++)
        begin
            b_item_next.acc[r] = a_item_reg.acc[r] + acc_t'(prod_reg[r]);
        end
    end

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (in_ready)
        begin
            a_valid_next = in_valid;
        end
        b_valid_next = b_valid_reg;
        if (a_ready)
        begin
            b_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_item_reg <= a_item_next;
            prod_reg   <= prod_next;
        end
        if (a_take)
        begin
            b_item_reg <= b_item_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;

endmodule

`default_nettype wire

>>> rtl/mvm_sat.sv
`default_nettype none

module mvm_sat
    import mvm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire mvm_item_t         in_item,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DIM*DATA_W-1:0]  out_data,
    output logic                   out_sat
);

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [DIM*DATA_W-1:0] data_reg;
    logic [DIM*DATA_W-1:0] data_next;
    logic                  sat_reg;
    logic                  sat_next;
    logic                  in_take;
    logic [SHIFT_W-1:0]    shifted;
    logic [SHIFT_W-DATA_W:0] upper;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        sat_next  = 1'b0;
        data_next = '0;
        shifted   = '0;
        upper     = '0;
        for (int r = 0; r < DIM; r++)
        begin
            shifted = SHIFT_W'(in_item.acc[r] >>> FRAC_BITS);
            upper   = shifted[SHIFT_W-1:DATA_W-1];
            if ((&upper) || !(|upper))
            begin
                data_next[r*DATA_W +: DATA_W] = shifted[DATA_W-1:0];
            end
            else
            begin
                sat_next = 1'b1;
                data_next[r*DATA_W +: DATA_W] = shifted[SHIFT_W-1] ? DATA_MIN : DATA_MAX;
            end
        end
    end

    // load beats end here without a result
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_take)
        begin
            out_valid_next = (in_item.cmd == CMD_MUL);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take && (in_item.cmd == CMD_MUL))
        begin
            data_reg <= data_next;
            sat_reg  <= sat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = data_reg;
    assign out_sat   = sat_reg;

endmodule

`default_nettype wire

>>> rtl/matrix_vector_multiply_4x4.sv
`default_nettype none

// channel   dir  beat                  tdata (low bit up)        tuser (low bit up)
// s_axis    in   load column / vector  elem_0, elem_1, elem_2,   cmd, column
//                                      elem_3
// m_axis    out  matrix times vector   out_0, out_1, out_2,      saturated
//                                      out_3
//
// one beat per cycle while the output is not stalled; a multiply beat passes
// through the cell chain (product then add in each column cell) and the
// saturating output register. load beats ride the same chain and write their
// column in the matching cell, so order with multiplies is kept. reset clears
// the stored matrix. a stalled output fills bubbles upstream before
// s_axis_tready drops.

module matrix_vector_multiply_4x4
    import mvm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [DIM*DATA_W-1:0] s_axis_tdata,   // elem_0 .. elem_3
    input  wire logic [USER_W-1:0]     s_axis_tuser,   // cmd, column
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [DIM*DATA_W-1:0]      m_axis_tdata,   // out_0 .. out_3
    output logic [0:0]                 m_axis_tuser    // saturated
);

    logic      chain_valid [DIM+1];
    logic      chain_ready [DIM+1];
    mvm_item_t chain_item  [DIM+1];

    always_comb
    begin
        chain_item[0].cmd    = cmd_t'(s_axis_tuser[0]);
        chain_item[0].column = s_axis_tuser[COL_W:1];
        chain_item[0].live   = 1'b1;
        for (int r = 0; r < DIM; r++)
        begin
            chain_item[0].vec[r] = s_axis_tdata[r*DATA_W +: DATA_W];
        end
        chain_item[0].acc = '0;
    end

    assign chain_valid[0] = s_axis_tvalid;
    assign s_axis_tready  = chain_ready[0];

    for (genvar k = 0; k < DIM; k++)
    begin : g_cell
        mvm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_item   (chain_item[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_item  (chain_item[k+1])
        );
    end

    mvm_sat u_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[DIM]),
        .in_ready  (chain_ready[DIM]),
        .in_item   (chain_item[DIM]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_sat   (m_axis_tuser[0])
    );

endmodule

`default_nettype wire
